FILE: design/ccsm_pkg.sv
package ccsm_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int MODE_W     = 3;

  typedef logic [1:0]        reg_idx_t;
  typedef logic [MODE_W-1:0] cmp_mode_t;

  // register index, taken from paddr[4:3]
  localparam reg_idx_t REG_MODULUS = 2'd0;
  localparam reg_idx_t REG_MODE    = 2'd1;
  localparam reg_idx_t REG_BOUND   = 2'd2;
  localparam reg_idx_t REG_DIFF    = 2'd3;

  localparam cmp_mode_t CMP_EQ     = 3'd0;
  localparam cmp_mode_t CMP_LT     = 3'd1;
  localparam cmp_mode_t CMP_LE     = 3'd2;
  localparam cmp_mode_t CMP_NEVER  = 3'd3;
  localparam cmp_mode_t CMP_NE     = 3'd4;
  localparam cmp_mode_t CMP_GE     = 3'd5;
  localparam cmp_mode_t CMP_GT     = 3'd6;
  localparam cmp_mode_t CMP_ALWAYS = 3'd7;

endpackage

FILE: design/compare_conditional_sub_mod.sv
// Streams WORD_WIDTH-bit words: each raw operand is compared with bound under compare_mode,
// reduced modulo modulus, and when the comparison held, diff is subtracted modulo modulus;
// a modulus below 2 gives 0. One request is taken per clock while in_stall is low; it
// passes an input register, the remainder pipeline, which retires one operand bit per
// stage, a final subtract stage and a full output register, which with a one-entry skid
// buffer decouples the sides, so in_stall is registered. After any write to modulus or
// diff, in_stall stays high while a one-bit-per-cycle unit reduces diff modulo modulus.
// Registers sit at byte addresses 0, 8, 16, 24 (modulus, compare_mode, bound, diff), 64-bit data.
module compare_conditional_sub_mod #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [WORD_WIDTH-1:0]             in_operand,
  input  logic                              in_last_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [WORD_WIDTH-1:0]             out_value,
  output logic                              out_last_out,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ccsm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ccsm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ccsm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int W    = WORD_WIDTH;
  localparam int CW   = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(W);

  // ---------------- configuration ----------------
  logic [W-1:0]              modulus_r, bound_r, diff_r;
  ccsm_pkg::cmp_mode_t       mode_r;
  ccsm_pkg::reg_idx_t        cfg_idx;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(2);
      mode_r    <= ccsm_pkg::CMP_ALWAYS;
      bound_r   <= '0;
      diff_r    <= W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        ccsm_pkg::REG_MODULUS: modulus_r <= cfg_pwdata[W-1:0];
        ccsm_pkg::REG_MODE:    mode_r    <= cfg_pwdata[ccsm_pkg::MODE_W-1:0];
        ccsm_pkg::REG_BOUND:   bound_r   <= cfg_pwdata[W-1:0];
        ccsm_pkg::REG_DIFF:    diff_r    <= cfg_pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ccsm_pkg::REG_MODULUS: cfg_prdata = ccsm_pkg::CFG_DATA_W'(modulus_r);
      ccsm_pkg::REG_MODE:    cfg_prdata = ccsm_pkg::CFG_DATA_W'(mode_r);
      ccsm_pkg::REG_BOUND:   cfg_prdata = ccsm_pkg::CFG_DATA_W'(bound_r);
      ccsm_pkg::REG_DIFF:    cfg_prdata = ccsm_pkg::CFG_DATA_W'(diff_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------- diff mod modulus, one bit per cycle ----------------
  logic          dr_busy_r;
  logic [CW-1:0] dr_cnt_r;
  logic [W-1:0]  dr_rem_r, dr_src_r;
  logic [W-1:0]  dmod_r, mdiff_r;
  logic [W:0]    dr_trial;
  logic [W+1:0]  dr_sub;
  logic [W-1:0]  dr_rem_nxt;
  logic          dr_start;

  assign dr_start   = cfg_wr && (cfg_idx == ccsm_pkg::REG_MODULUS ||
                                 cfg_idx == ccsm_pkg::REG_DIFF);
  assign dr_trial   = {dr_rem_r, dr_src_r[W-1]};
  assign dr_sub     = {1'b0, dr_trial} - {2'b00, modulus_r};
  assign dr_rem_nxt = dr_sub[W+1] ? dr_trial[W-1:0] : dr_sub[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_busy_r <= 1'b0;
      dr_cnt_r  <= '0;
      dmod_r    <= W'(1);
      mdiff_r   <= W'(1);
    end else if (dr_start) begin
      dr_busy_r <= 1'b1;
      dr_cnt_r  <= '0;
      dr_rem_r  <= '0;
      dr_src_r  <= (cfg_idx == ccsm_pkg::REG_DIFF) ? cfg_pwdata[W-1:0] : diff_r;
    end else if (dr_busy_r) begin
      if (dr_cnt_r == CNT_LAST) begin
        dmod_r    <= dr_rem_r;
        mdiff_r   <= modulus_r - dr_rem_r;
        dr_busy_r <= 1'b0;
      end else begin
        dr_rem_r <= dr_rem_nxt;
        dr_src_r <= dr_src_r << 1;
        dr_cnt_r <= dr_cnt_r + CW'(1);
      end
    end
  end

  // ---------------- pipeline ----------------
  logic          skid_v_r;
  logic          adv;
  logic          v_r    [0:W];
  logic          last_r [0:W];
  logic [W-1:0]  sh_r   [0:W-1];
  logic [W-1:0]  rem_r  [1:W];
  logic          hit_r  [1:W];
  logic          hit_c;

  assign adv      = !skid_v_r;
  assign in_stall = dr_busy_r || skid_v_r;

  always_comb begin
    case (mode_r)
      ccsm_pkg::CMP_EQ:     hit_c = (sh_r[0] == bound_r);
      ccsm_pkg::CMP_LT:     hit_c = (sh_r[0] <  bound_r);
      ccsm_pkg::CMP_LE:     hit_c = (sh_r[0] <= bound_r);
      ccsm_pkg::CMP_NEVER:  hit_c = 1'b0;
      ccsm_pkg::CMP_NE:     hit_c = (sh_r[0] != bound_r);
      ccsm_pkg::CMP_GE:     hit_c = (sh_r[0] >= bound_r);
      ccsm_pkg::CMP_GT:     hit_c = (sh_r[0] >  bound_r);
      default:              hit_c = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid && !dr_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r[0]   <= in_operand;
      last_r[0] <= in_last_in;
    end
  end

  // stage j retires operand bit W-j into a running remainder below modulus
  for (genvar j = 1; j <= W; j++) begin : g_stage
    logic [W-1:0] prev;
    logic [W:0]   trial;
    logic [W+1:0] sub;

    if (j == 1) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = rem_r[j-1];
    end

    assign trial = {prev, sh_r[j-1][W-1]};
    assign sub   = {1'b0, trial} - {2'b00, modulus_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= sub[W+1] ? trial[W-1:0] : sub[W-1:0];
        last_r[j] <= last_r[j-1];
      end
    end

    if (j == 1) begin : g_hit_first
      always_ff @(posedge clk) begin
        if (adv) begin
          hit_r[j] <= hit_c;
        end
      end
    end else begin : g_hit_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          hit_r[j] <= hit_r[j-1];
        end
      end
    end

    if (j < W) begin : g_shift
      always_ff @(posedge clk) begin
        if (adv) begin
          sh_r[j] <= sh_r[j-1] << 1;
        end
      end
    end
  end

  // final stage: conditional modular subtract
  logic          f_v_r, f_last_r;
  logic [W-1:0]  f_val_r;
  logic [W:0]    f_sub;
  logic [W-1:0]  f_add, f_res;
  logic          m_small;

  assign m_small = (modulus_r[W-1:1] == '0);
  assign f_sub   = {1'b0, rem_r[W]} - {1'b0, dmod_r};
  assign f_add   = rem_r[W] + mdiff_r;

  always_comb begin
    if (m_small) begin
      f_res = '0;
    end else if (!hit_r[W]) begin
      f_res = rem_r[W];
    end else if (!f_sub[W]) begin
      f_res = f_sub[W-1:0];
    end else begin
      f_res = f_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_val_r  <= f_res;
      f_last_r <= last_r[W];
    end
  end

  // ---------------- output register and skid ----------------
  logic          out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [W-1:0]  out_val_r, out_val_nxt;
  logic          skid_v_nxt, skid_last_r, skid_last_nxt;
  logic [W-1:0]  skid_val_r, skid_val_nxt;
  logic          out_take;

  assign out_take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt     = out_v_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    skid_v_nxt    = skid_v_r;
    skid_val_nxt  = skid_val_r;
    skid_last_nxt = skid_last_r;
    if (skid_v_r) begin
      if (out_take) begin
        out_v_nxt    = 1'b1;
        out_val_nxt  = skid_val_r;
        out_last_nxt = skid_last_r;
        skid_v_nxt   = 1'b0;
      end
    end else if (out_take || !out_v_r) begin
      out_v_nxt    = f_v_r;
      out_val_nxt  = f_val_r;
      out_last_nxt = f_last_r;
    end else if (f_v_r) begin
      skid_v_nxt    = 1'b1;
      skid_val_nxt  = f_val_r;
      skid_last_nxt = f_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r   <= out_val_nxt;
    out_last_r  <= out_last_nxt;
    skid_val_r  <= skid_val_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_valid    = out_v_r;
  assign out_value    = out_val_r;
  assign out_last_out = out_last_r;

endmodule

FILE: design/ccsm_checker.sv
module ccsm_checker #(
  parameter int WORD_WIDTH = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [WORD_WIDTH-1:0]             out_value,
  input logic                              out_last_out,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [ccsm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input logic [ccsm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input logic                              cfg_pready
);

  localparam int W     = WORD_WIDTH;
  localparam int CNT_W = $clog2(W + 8);

  logic             cfg_wr, in_acc, out_acc;
  logic [W-1:0]     mod_sh_r;
  logic [CNT_W-1:0] cnt_r;

  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // shadow of the modulus as seen on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_sh_r <= W'(2);
    end else if (cfg_wr && cfg_paddr[4:3] == ccsm_pkg::REG_MODULUS) begin
      mod_sh_r <= cfg_pwdata[W-1:0];
    end
  end

  // requests in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((mod_sh_r < W'(2) && out_value == '0) ||
                   (mod_sh_r >= W'(2) && out_value < mod_sh_r)))
    else $error("result not reduced below modulus");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != '0)
    else $error("result delivered without a pending request");

  a_reduce_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[4:3] == ccsm_pkg::REG_MODULUS ||
                cfg_paddr[4:3] == ccsm_pkg::REG_DIFF)) |=> in_stall)
    else $error("input open while diff is being reduced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_value) && $stable(out_last_out)))
    else $error("stalled result changed");

endmodule

bind compare_conditional_sub_mod ccsm_checker #(.WORD_WIDTH(WORD_WIDTH)) u_ccsm_checker (.*);
